// ----- design/rac_pkg.sv -----
// Package for the repeater access sequencer.
// Holds item codes, sequencer modes, register indexes and controller/datapath types.
// No dependencies.
package rac_pkg;

  localparam int HISTORY_DEPTH_DEF = 10;

  localparam int CFG_INDEX_W = 3;
  localparam int IN_DATA_W   = 64;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 16;
  localparam int CFG_DATA_W  = 32;

  localparam int FREQ_W  = 14;
  localparam int MAG_W   = 32;
  localparam int VOL_W   = 16;
  localparam int COUNT_W = 8;
  localparam int ENTRY_W = MAG_W + FREQ_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_SQUELCH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAG_MIN   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCESS    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANNOUNCE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_HANG      = 3'd6;

  localparam logic signed [VOL_W-1:0] SQUELCH_RST   = -16'sd7680;
  localparam logic [FREQ_W-1:0]       CENTER_RST    = 14'd1750;
  localparam logic [FREQ_W-1:0]       TOLERANCE_RST = 14'd100;
  localparam logic [MAG_W-1:0]        MAG_MIN_RST   = 32'd100000;
  localparam logic [COUNT_W-1:0]      ACCESS_RST    = 8'd2;
  localparam logic [COUNT_W-1:0]      ANNOUNCE_RST  = 8'd3;
  localparam logic [COUNT_W-1:0]      HANG_RST      = 8'd10;

  typedef enum logic [1:0] {
    OP_PEAK   = 2'd0,
    OP_TICK   = 2'd1,
    OP_BUTTON = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WELCOME = 2'd1,
    MODE_REPEAT  = 2'd2,
    MODE_CLOSING = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_DRAIN,
    CS_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/repeater_access_sequencer.sv -----
// Top level of the repeater access sequencer: controller plus datapath.
// Depends on rac_pkg, rac_ctrl, rac_datapath (and rac_ram below it).
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------------
//  s_axis    | s_axis_tvalid/s_axis_tready  | tuser operation, tdata item fields
//  m_axis    | m_axis_tvalid/m_axis_tready  | tdata result fields
//  cfg       | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// A tick on a full ring reads one history entry per cycle from the ring RAM, then
// passes through a drain state and an update state. Other requests go straight to
// the update state. Reset is synchronous; the ring needs no clearing pass.
// A new request is taken while a result waits in the output register; the update
// of the next request waits until that result is taken. cfg_ready is always high.
module repeater_access_sequencer #(
  parameter int HISTORY_DEPTH = rac_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [13:0] peak_frequency, [45:14] peak_magnitude, [61:46] volume_level,
  // [62] button_level, [63] zero
  input  logic [rac_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] operation
  input  logic [rac_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] mode, [2] rx_lamp, [3] tx_lamp, [4] audio_pass, [5] play_start,
  // [6] play_clip, [7] carrier_detect, [8] tone_seen, [15:9] zero
  output logic [rac_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rac_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rac_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rac_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rac_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cmd           (cmd),
    .status        (status)
  );

  rac_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

// ----- design/rac_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/rac_datapath.sv -----
// Datapath: configuration registers, peak history ring, tone scan, repeater
// state update and output register. Depends on rac_pkg and rac_ram.
module rac_datapath #(
  parameter int HISTORY_DEPTH = rac_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [rac_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rac_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [rac_pkg::IN_USER_W-1:0]     s_axis_tuser,
  input  logic [rac_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rac_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  rac_pkg::dp_cmd_t                  cmd,
  output rac_pkg::dp_status_t               status
);
  import rac_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);

  // configuration
  logic signed [VOL_W-1:0] squelch;
  logic [FREQ_W-1:0]       center;
  logic [FREQ_W-1:0]       tolerance;
  logic [MAG_W-1:0]        mag_min;
  logic [COUNT_W-1:0]      access_ticks;
  logic [COUNT_W-1:0]      announce_ticks;
  logic [COUNT_W-1:0]      hang_ticks;

  // captured request
  op_t                     item_op;
  logic [FREQ_W-1:0]       item_freq;
  logic [MAG_W-1:0]        item_mag;
  logic signed [VOL_W-1:0] item_vol;
  logic                    item_btn;

  // architectural state
  mode_t              mode;
  logic [COUNT_W-1:0] tick_count;
  logic               carrier;
  logic [AW-1:0]      head;
  logic [FW-1:0]      fill;
  logic               button_last;
  logic               rx_lamp;
  logic               tx_lamp;
  logic               pass;

  // scan
  logic [AW-1:0]        scan_addr;
  logic                 rd_valid;
  logic [ENTRY_W-1:0]   rd_data;
  logic signed [15:0]   win_lo;
  logic signed [15:0]   win_hi;
  logic                 tone_acc;
  logic                 entry_match;
  logic signed [15:0]   rd_freq;
  logic                 ring_full;

  // next values
  mode_t              mode_next;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] count_inc;
  logic               carrier_next;
  logic               rx_next;
  logic               tx_next;
  logic               pass_next;
  logic               btn_next;
  logic               start;
  logic               clip;
  logic               tone;

  assign ring_full = (fill == FW'(HISTORY_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      squelch        <= SQUELCH_RST;
      center         <= CENTER_RST;
      tolerance      <= TOLERANCE_RST;
      mag_min        <= MAG_MIN_RST;
      access_ticks   <= ACCESS_RST;
      announce_ticks <= ANNOUNCE_RST;
      hang_ticks     <= HANG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SQUELCH:   squelch        <= $signed(cfg_data[VOL_W-1:0]);
        CFG_CENTER:    center         <= cfg_data[FREQ_W-1:0];
        CFG_TOLERANCE: tolerance      <= cfg_data[FREQ_W-1:0];
        CFG_MAG_MIN:   mag_min        <= cfg_data[MAG_W-1:0];
        CFG_ACCESS:    access_ticks   <= cfg_data[COUNT_W-1:0];
        CFG_ANNOUNCE:  announce_ticks <= cfg_data[COUNT_W-1:0];
        CFG_HANG:      hang_ticks     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op   <= op_t'(s_axis_tuser);
      item_freq <= s_axis_tdata[13:0];
      item_mag  <= s_axis_tdata[45:14];
      item_vol  <= $signed(s_axis_tdata[61:46]);
      item_btn  <= s_axis_tdata[62];
      win_lo    <= $signed({2'b00, center}) - $signed({2'b00, tolerance});
      win_hi    <= $signed({2'b00, center}) + $signed({2'b00, tolerance});
    end
  end

  rac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.exec && (item_op == OP_PEAK)),
    .wr_addr (head),
    .wr_data ({item_mag, item_freq}),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  assign rd_freq     = $signed({2'b00, rd_data[FREQ_W-1:0]});
  assign entry_match = (rd_freq > win_lo) && (rd_freq < win_hi)
                       && (rd_data[ENTRY_W-1:FREQ_W] > mag_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      tone_acc  <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cmd.load) begin
        scan_addr <= '0;
        tone_acc  <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_addr <= scan_addr + AW'(1);
        end
        if (rd_valid && entry_match) begin
          tone_acc <= 1'b1;
        end
      end
    end
  end

  assign status.need_scan = (op_t'(s_axis_tuser) == OP_TICK) && ring_full;
  assign status.scan_last = (scan_addr == AW'(HISTORY_DEPTH - 1));
  assign status.out_free  = !m_axis_tvalid || m_axis_tready;

  assign count_inc = tick_count + COUNT_W'(1);

  always_comb begin
    mode_next    = mode;
    count_next   = tick_count;
    carrier_next = carrier;
    rx_next      = rx_lamp;
    tx_next      = tx_lamp;
    pass_next    = pass;
    btn_next     = button_last;
    start        = 1'b0;
    clip         = 1'b0;
    tone         = 1'b0;
    case (item_op)
      OP_TICK: begin
        carrier_next = (item_vol > squelch);
        tone         = tone_acc;
        rx_next      = (mode == MODE_IDLE);
        tx_next      = (mode != MODE_IDLE);
        case (mode)
          MODE_IDLE: begin
            count_next = (tone_acc && carrier_next) ? count_inc : '0;
            if (count_next >= access_ticks) begin
              start      = 1'b1;
              clip       = 1'b1;
              mode_next  = MODE_WELCOME;
              count_next = '0;
            end
          end
          MODE_WELCOME: begin
            count_next = count_inc;
            if (count_inc > announce_ticks) begin
              pass_next  = 1'b1;
              mode_next  = MODE_REPEAT;
              count_next = '0;
            end
          end
          MODE_REPEAT: begin
            count_next = carrier_next ? '0 : count_inc;
            if (count_next > hang_ticks) begin
              pass_next  = 1'b0;
              start      = 1'b1;
              mode_next  = MODE_CLOSING;
              count_next = '0;
            end
          end
          default: begin
            count_next = count_inc;
            if (count_inc > announce_ticks) begin
              pass_next  = 1'b0;
              mode_next  = MODE_IDLE;
              count_next = '0;
            end
          end
        endcase
      end
      OP_BUTTON: begin
        if (!button_last && item_btn) begin
          mode_next = MODE_WELCOME;
        end
        btn_next = item_btn;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      tick_count    <= '0;
      carrier       <= 1'b0;
      head          <= '0;
      fill          <= '0;
      button_last   <= 1'b1;
      rx_lamp       <= 1'b0;
      tx_lamp       <= 1'b0;
      pass          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cmd.exec) begin
        mode          <= mode_next;
        tick_count    <= count_next;
        carrier       <= carrier_next;
        button_last   <= btn_next;
        rx_lamp       <= rx_next;
        tx_lamp       <= tx_next;
        pass          <= pass_next;
        m_axis_tvalid <= 1'b1;
        if (item_op == OP_PEAK) begin
          head <= (head == AW'(HISTORY_DEPTH - 1)) ? '0 : head + AW'(1);
          if (!ring_full) begin
            fill <= fill + FW'(1);
          end
        end
      end
    end
  end

  // mode, rx, tx, pass, start, clip, carrier, tone
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      m_axis_tdata <= {7'd0, tone, carrier_next, clip, start, pass_next,
                       tx_next, rx_next, mode_next};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(HISTORY_DEPTH))
    else $error("ring fill beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(HISTORY_DEPTH - 1))
    else $error("ring head beyond depth");

  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before taken");

  a_scan_full: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ring_full)
    else $error("scan of a ring that is not full");

endmodule

// ----- design/rac_ctrl.sv -----
// Controller: request handshake and scan sequencing for the datapath.
// Depends on rac_pkg.
module rac_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  output rac_pkg::dp_cmd_t    cmd,
  input  rac_pkg::dp_status_t status
);
  import rac_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    cmd           = '0;
    case (state)
      CS_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = status.need_scan ? CS_SCAN : CS_EXEC;
        end
      end
      CS_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = CS_DRAIN;
        end
      end
      CS_DRAIN: begin
        state_next = CS_EXEC;
      end
      CS_EXEC: begin
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == CS_SCAN && status.scan_last) |=> state == CS_DRAIN)
    else $error("scan did not end after last entry");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    (state == CS_EXEC && status.out_free) |=> state == CS_IDLE)
    else $error("result not issued");

  a_drain_exec: assert property (@(posedge clk) disable iff (rst)
    state == CS_DRAIN |=> state == CS_EXEC)
    else $error("drain not followed by update");

endmodule
